[rtl/lsi_pkg.sv]
// lsi_pkg: widths, job and divider stage types, and the divider step
// shared by the segment intersection front end, queue and back end
// no dependencies
`timescale 1ns / 1ps

package lsi_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;

  // coordinate difference, product, cross product, numerator widths
  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;
  localparam int CW  = PW + 1;
  localparam int P1W = COORD_BITS + CW;
  localparam int P2W = CW + DW;
  localparam int NW  = P2W + 1;
  // quotient magnitude bits and shifted dividend width
  localparam int QW  = COORD_BITS + FRAC_BITS;
  localparam int MW  = NW + FRAC_BITS;

  localparam int OUT_W   = 32;
  localparam int IN_DATA_W  = 8 * COORD_BITS;
  localparam int OUT_DATA_W = 2 * OUT_W;

  // one classified item handed from front end to back end
  typedef struct packed {
    logic                 hit;
    logic                 neg_x;
    logic                 neg_y;
    logic [NW-1:0]        mag_x;
    logic [NW-1:0]        mag_y;
    logic [CW-1:0]        den;
  } lsi_job_t;

  // partial remainder and dividend/quotient shift register of one divider
  typedef struct packed {
    logic [CW-1:0] rem;
    logic [QW-1:0] dq;
  } lsi_div_t;

  // state of one back end stage
  typedef struct packed {
    logic          hit;
    logic          neg_x;
    logic          neg_y;
    logic [CW-1:0] den;
    lsi_div_t      dx;
    lsi_div_t      dy;
  } lsi_stage_t;

  // one restoring division step: bring down a dividend bit, shift in a quotient bit
  function automatic lsi_div_t lsi_div_step(input lsi_div_t cur, input logic [CW-1:0] den);
    logic [CW:0] trial;
    logic [CW:0] diff;
    lsi_div_t    res;
    trial = {cur.rem, cur.dq[QW-1]};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      res.rem = diff[CW-1:0];
      res.dq  = {cur.dq[QW-2:0], 1'b1};
    end else begin
      res.rem = trial[CW-1:0];
      res.dq  = {cur.dq[QW-2:0], 1'b0};
    end
    return res;
  endfunction

  // split a numerator magnitude into initial remainder and dividend bits
  function automatic lsi_div_t lsi_div_init(input logic [NW-1:0] mag);
    logic [MW-1:0] m;
    lsi_div_t      res;
    m       = MW'(mag) << FRAC_BITS;
    res.rem = m[QW +: CW];
    res.dq  = m[QW-1:0];
    return res;
  endfunction

endpackage

[rtl/lsi_front.sv]
// lsi_front: difference, cross product and hit classification pipeline,
// then numerators of the intersection point; uses lsi_pkg
`timescale 1ns / 1ps

module lsi_front import lsi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [IN_DATA_W-1:0] in_data,
  output logic                 job_valid,
  output lsi_job_t             job
);

  logic signed [COORD_BITS-1:0] c [8];

  logic [5:0] v_r;

  logic signed [COORD_BITS-1:0] ax1_r, ay1_r, ax2_r, ay2_r, ax3_r, ay3_r, ax4_r, ay4_r;
  logic signed [DW-1:0] rx1_r, ry1_r, sx1_r, sy1_r, qx1_r, qy1_r;
  logic signed [DW-1:0] rx2_r, ry2_r, rx3_r, ry3_r, rx4_r, ry4_r;
  logic signed [PW-1:0] p_rs_r, p_rs2_r, p_qs_r, p_qs2_r, p_qr_r, p_qr2_r;
  logic signed [CW-1:0] den3_r, tn3_r, un3_r;
  logic signed [CW-1:0] den4_r, tn4_r;
  logic                 hit4_r, hit5_r;
  logic signed [P1W-1:0] bx5_r, by5_r;
  logic signed [P2W-1:0] tx5_r, ty5_r;
  logic [CW-1:0]         den5_r;
  lsi_job_t              job_r;

  logic signed [CW-1:0] den_abs, tn_n, un_n;
  logic signed [NW-1:0] nx, ny;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      c[i] = in_data[i*COORD_BITS +: COORD_BITS];
    end
  end

  always_comb begin
    den_abs = den3_r[CW-1] ? -den3_r : den3_r;
    tn_n    = den3_r[CW-1] ? -tn3_r  : tn3_r;
    un_n    = den3_r[CW-1] ? -un3_r  : un3_r;
    nx      = NW'(bx5_r) + NW'(tx5_r);
    ny      = NW'(by5_r) + NW'(ty5_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: direction and offset vectors
      ax1_r <= c[0];
      ay1_r <= c[1];
      rx1_r <= DW'(c[2]) - DW'(c[0]);
      ry1_r <= DW'(c[3]) - DW'(c[1]);
      sx1_r <= DW'(c[6]) - DW'(c[4]);
      sy1_r <= DW'(c[7]) - DW'(c[5]);
      qx1_r <= DW'(c[4]) - DW'(c[0]);
      qy1_r <= DW'(c[5]) - DW'(c[1]);
      // stage 2: cross product terms
      p_rs_r  <= rx1_r * sy1_r;
      p_rs2_r <= ry1_r * sx1_r;
      p_qs_r  <= qx1_r * sy1_r;
      p_qs2_r <= qy1_r * sx1_r;
      p_qr_r  <= qx1_r * ry1_r;
      p_qr2_r <= qy1_r * rx1_r;
      ax2_r <= ax1_r;
      ay2_r <= ay1_r;
      rx2_r <= rx1_r;
      ry2_r <= ry1_r;
      // stage 3: den, tn, un
      den3_r <= CW'(p_rs_r) - CW'(p_rs2_r);
      tn3_r  <= CW'(p_qs_r) - CW'(p_qs2_r);
      un3_r  <= CW'(p_qr_r) - CW'(p_qr2_r);
      ax3_r <= ax2_r;
      ay3_r <= ay2_r;
      rx3_r <= rx2_r;
      ry3_r <= ry2_r;
      // stage 4: sign normalize and parameter range test
      hit4_r <= (den3_r != '0) && !tn_n[CW-1] && (tn_n <= den_abs)
                && !un_n[CW-1] && (un_n <= den_abs);
      den4_r <= den_abs;
      tn4_r  <= tn_n;
      ax4_r <= ax3_r;
      ay4_r <= ay3_r;
      rx4_r <= rx3_r;
      ry4_r <= ry3_r;
      // stage 5: point numerator terms
      bx5_r  <= ax4_r * den4_r;
      by5_r  <= ay4_r * den4_r;
      tx5_r  <= tn4_r * rx4_r;
      ty5_r  <= tn4_r * ry4_r;
      den5_r <= den4_r;
      hit5_r <= hit4_r;
      // stage 6: magnitudes and signs for the divider
      job_r.hit   <= hit5_r;
      job_r.neg_x <= nx[NW-1];
      job_r.neg_y <= ny[NW-1];
      job_r.mag_x <= nx[NW-1] ? -nx : nx;
      job_r.mag_y <= ny[NW-1] ? -ny : ny;
      job_r.den   <= den5_r;
    end
  end

  assign job_valid = v_r[5];
  assign job       = job_r;

endmodule

[rtl/lsi_queue.sv]
// lsi_queue: two-entry job queue between front end and back end
// uses lsi_pkg
`timescale 1ns / 1ps

module lsi_queue import lsi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  lsi_job_t push_job,
  input  logic     pop,
  output logic     full,
  output logic     not_empty,
  output lsi_job_t head
);

  lsi_job_t   ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[rtl/lsi_back.sv]
// lsi_back: pipelined restoring dividers for both point coordinates,
// one quotient bit per stage, plus sign and miss fixup; uses lsi_pkg
`timescale 1ns / 1ps

module lsi_back import lsi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  job_valid,
  input  lsi_job_t              job,
  output logic                  res_valid,
  output logic                  res_hit,
  output logic [OUT_DATA_W-1:0] res_data
);

  lsi_stage_t st_r [QW];
  lsi_stage_t st_in [QW];
  logic [QW-1:0] v_r;
  lsi_stage_t    head;

  logic              valid_o_r, hit_o_r;
  logic [OUT_W-1:0]  x_o_r, y_o_r;
  logic signed [QW:0] sx, sy;

  always_comb begin
    head.hit   = job.hit;
    head.neg_x = job.neg_x;
    head.neg_y = job.neg_y;
    head.den   = job.den;
    head.dx    = lsi_div_init(job.mag_x);
    head.dy    = lsi_div_init(job.mag_y);
    for (int i = 0; i < QW; i++) begin
      st_in[i] = (i == 0) ? head : st_r[(i == 0) ? 0 : i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= '0;
      valid_o_r <= 1'b0;
    end else if (en) begin
      v_r       <= {v_r[QW-2:0], job_valid};
      valid_o_r <= v_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QW; i++) begin
        st_r[i].hit   <= st_in[i].hit;
        st_r[i].neg_x <= st_in[i].neg_x;
        st_r[i].neg_y <= st_in[i].neg_y;
        st_r[i].den   <= st_in[i].den;
        st_r[i].dx    <= lsi_div_step(st_in[i].dx, st_in[i].den);
        st_r[i].dy    <= lsi_div_step(st_in[i].dy, st_in[i].den);
      end
      hit_o_r <= st_r[QW-1].hit;
      x_o_r   <= st_r[QW-1].hit ? OUT_W'(sx) : '0;
      y_o_r   <= st_r[QW-1].hit ? OUT_W'(sy) : '0;
    end
  end

  always_comb begin
    sx = st_r[QW-1].neg_x ? -$signed({1'b0, st_r[QW-1].dx.dq})
                          :  $signed({1'b0, st_r[QW-1].dx.dq});
    sy = st_r[QW-1].neg_y ? -$signed({1'b0, st_r[QW-1].dy.dq})
                          :  $signed({1'b0, st_r[QW-1].dy.dq});
  end

  assign res_valid = valid_o_r;
  assign res_hit   = hit_o_r;
  assign res_data  = {y_o_r, x_o_r};

endmodule

[rtl/line_segment_intersection.sv]
// line_segment_intersection: top level of the segment pair intersection block
// pipeline: 6 front stages, a queue entry, 32 divider stages and one output register
// throughput: one transaction per cycle while out_tready does not stall the output,
// set by the one-bit-per-stage dividers
// reset: synchronous active-low rst_n clears all valid bits; no data is reset
`timescale 1ns / 1ps

module line_segment_intersection import lsi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // cross_x, cross_y
  output logic [OUT_DATA_W-1:0] out_tdata,
  // hit
  output logic                  out_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready
);

  logic     front_en, front_valid;
  lsi_job_t front_job;
  logic     q_full, q_not_empty, q_push, q_pop;
  lsi_job_t q_head;
  logic     back_en;

  // front stalls only when its last stage holds a job the queue cannot take
  assign front_en  = !front_valid || !q_full;
  assign in_tready = front_en;
  assign q_push    = front_valid && !q_full;

  // back advances whenever the output register is free or being drained
  assign back_en = !out_tvalid || out_tready;
  assign q_pop   = back_en && q_not_empty;

  lsi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (front_en),
    .in_valid  (in_tvalid),
    .in_data   (in_tdata),
    .job_valid (front_valid),
    .job       (front_job)
  );

  lsi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (front_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  lsi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (back_en),
    .job_valid (q_pop),
    .job       (q_head),
    .res_valid (out_tvalid),
    .res_hit   (out_tuser),
    .res_data  (out_tdata)
  );

endmodule
